FILE: hw/rtl/pth_pkg.sv
// Package for the permutation test histogram: widths, action codes, helpers.
// Used by the top level, pth_hist_mem and the testbench; depends on nothing.
`timescale 1ns / 1ps
package pth_pkg;

  localparam int MaxBins  = 512;
  localparam int BinW     = $clog2(MaxBins);
  localparam int FracBits = 16;
  localparam int CntW     = 17;
  localparam logic [CntW-1:0] CntMax = '1;

  localparam int SampW = 18;
  localparam int SumW  = 40;
  localparam int SqW   = 56;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CFG_OBS   = 2'd0,
    CFG_PERM  = 2'd1,
    CFG_NOBS  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_SQRT,
    ST_EMIT
  } state_t;

  // Bin of a Q1.F value for a histogram of nbins bins, clamped to 0..nbins-1.
  function automatic logic [BinW-1:0] bin_of(input logic signed [SampW-1:0] x,
                                             input logic [BinW:0] nbins);
    logic signed [SampW:0] t;
    logic [SampW+BinW+1:0] p;
    logic [SampW+BinW+1:0] idx;
    begin
      t = {x[SampW-1], x} + (SampW+1)'(1 << FracBits);
      p = {{(BinW+2){1'b0}}, t[SampW-1:0]} * {{(SampW+1){1'b0}}, nbins};
      idx = p >> (FracBits + 1);
      if (t[SampW]) bin_of = '0;
      else if (idx >= {{(SampW+1){1'b0}}, nbins}) bin_of = BinW'(nbins - 1'b1);
      else bin_of = idx[BinW-1:0];
    end
  endfunction

endpackage

FILE: hw/rtl/permutation_test_histogram.sv
// Top level of the permutation test histogram; instantiates pth_hist_mem,
// pth_divider and pth_sqrt. Depends on pth_pkg.
`timescale 1ns / 1ps
// A start request clears the histogram memory one bin per cycle (also after
// reset) and busy stays high meanwhile. Add requests leave busy low, so samples
// may arrive back to back; the bin count is updated by a read-modify-write
// pipeline with forwarding from the write stage. A read request is answered
// through the READ and EMIT states. A finish request runs four 64-bit divisions
// on a shared iterative divider and a 32-step square root, then puts the
// statistics record on the outputs; busy falls in the cycle after the record.
// Results appear for one cycle with out_valid high and cannot be stalled.
module permutation_test_histogram (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic signed [17:0] in_sample_value,
  input  logic [8:0]  in_bin_index,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output logic        out_valid,
  output logic        out_result_kind,
  output logic signed [17:0] out_mean_value,
  output logic [16:0] out_std_dev,
  output logic [16:0] out_pseudo_p,
  output logic signed [16:0] out_expected_value,
  output logic [16:0] out_extreme_count,
  output logic [16:0] out_sample_total,
  output logic [8:0]  out_lowest_bin,
  output logic [8:0]  out_highest_bin,
  output logic [8:0]  out_observed_bin,
  output logic [16:0] out_bin_count
);

  localparam int BW = pth_pkg::BinW;
  localparam int CW = pth_pkg::CntW;

  // configuration
  logic signed [17:0] obs_r;
  logic [16:0] perm_r;
  logic [19:0] nobs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obs_r <= '0;
      perm_r <= 17'd999;
      nobs_r <= 20'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        pth_pkg::CFG_OBS:  obs_r <= cfg_data[17:0];
        pth_pkg::CFG_PERM: perm_r <= cfg_data[16:0];
        pth_pkg::CFG_NOBS: nobs_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // bin count from the permutation count
  logic [BW:0] nbins_calc;
  logic [17:0] perm_p1;
  always_comb begin
    perm_p1 = {1'b0, perm_r} + 18'd1;
    if (perm_r <= 17'd10) nbins_calc = (BW+1)'(10);
    else if (perm_r <= 17'd100) nbins_calc = (BW+1)'(20);
    else if (perm_r <= 17'd1000) nbins_calc = (BW+1)'(perm_p1 >> 2);
    else nbins_calc = (BW+1)'(300);
    if (nbins_calc > (BW+1)'(pth_pkg::MaxBins)) nbins_calc = (BW+1)'(pth_pkg::MaxBins);
  end

  logic [BW-1:0] obs_bin_calc;
  always_comb begin
    obs_bin_calc = pth_pkg::bin_of(obs_r, nbins_calc);
    if (obs_bin_calc == '0) obs_bin_calc = BW'(1);
  end

  pth_pkg::state_t state_r, state_nxt;
  logic [BW:0] nbins_r;
  logic [BW-1:0] obsbin_r, minb_r, maxb_r;
  logic [BW:0] clr_r;
  logic [CW-1:0] scnt_r, tail_r;
  logic signed [pth_pkg::SumW-1:0] vsum_r;
  logic [pth_pkg::SqW-1:0] ssum_r;

  logic acc;
  assign acc = start && !busy;
  logic do_start, do_add, do_fin, do_read;
  assign do_start = acc && (in_action == pth_pkg::ACT_START);
  assign do_add   = acc && (in_action == pth_pkg::ACT_ADD) && (scnt_r != pth_pkg::CntMax);
  assign do_fin   = acc && (in_action == pth_pkg::ACT_FINISH);
  assign do_read  = acc && (in_action == pth_pkg::ACT_READ);

  // add pipeline: stage 1 reads the bin, stage 2 writes it back
  logic [BW-1:0] sbin;
  assign sbin = pth_pkg::bin_of(in_sample_value, nbins_r);
  logic          s1_v_r;
  logic [BW-1:0] s1_bin_r;
  logic [CW-1:0] wb_data;
  logic          wb_v_r;
  logic [BW-1:0] wb_bin_r;
  logic [CW-1:0] wb_data_r;
  logic [CW-1:0] mem_rd;
  logic [CW-1:0] cur;

  // Forward the previous write when it hit the same bin.
  assign cur = (wb_v_r && wb_bin_r == s1_bin_r) ? wb_data_r : mem_rd;
  assign wb_data = (cur == pth_pkg::CntMax) ? cur : cur + 1'b1;

  logic mem_we;
  logic [BW-1:0] mem_wa;
  logic [CW-1:0] mem_wd;
  always_comb begin
    mem_we = 1'b0;
    mem_wa = s1_bin_r;
    mem_wd = wb_data;
    if (state_r == pth_pkg::ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_r[BW-1:0];
      mem_wd = (clr_r[BW-1:0] == obsbin_r) ? CW'(1) : '0;
    end else if (s1_v_r) begin
      mem_we = 1'b1;
    end
  end

  pth_hist_mem u_mem (
    .clk(clk), .rd_en(do_add || do_read),
    .rd_addr(do_add ? sbin : in_bin_index[BW-1:0]), .rd_data(mem_rd),
    .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd)
  );

  always_ff @(posedge clk) begin
    s1_bin_r <= sbin;
    wb_bin_r <= s1_bin_r;
    wb_data_r <= wb_data;
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      wb_v_r <= 1'b0;
    end else begin
      s1_v_r <= do_add;
      wb_v_r <= s1_v_r;
    end
  end

  // read request bookkeeping
  logic rd_oor_r;
  logic [BW-1:0] rd_addr_r;
  always_ff @(posedge clk) begin
    if (do_read) begin
      rd_oor_r <= ({1'b0, in_bin_index} >= (BW+1)'(nbins_r));
      rd_addr_r <= in_bin_index[BW-1:0];
    end
  end

  // finish: divisions and square root
  logic div_go, div_done, sq_go, sq_done;
  logic [63:0] div_a, div_q;
  logic [39:0] div_b;
  logic [31:0] sq_root;
  logic [1:0] dstep_r, dstep_nxt;
  logic signed [17:0] mean_r;
  logic [63:0] q_r;
  logic [16:0] pp_r;
  logic signed [16:0] ev_r;
  logic [63:0] var_val;
  logic signed [39:0] mean_full;
  logic [35:0] msq;
  logic [39:0] vabs;

  assign vabs = vsum_r[39] ? 40'(-vsum_r) : vsum_r;
  assign mean_full = vsum_r[39] ? 40'(-$signed(div_q[39:0])) : $signed(div_q[39:0]);
  assign msq = 36'($signed(mean_r) * $signed(mean_r));
  assign var_val = (q_r >= {28'd0, msq}) ? q_r - {28'd0, msq} : '0;

  // The operands follow the step that the divider is being started on.
  always_comb begin
    div_a = {24'd0, vabs};
    div_b = {23'd0, scnt_r};
    case (dstep_nxt)
      2'd1: begin
        div_a = {8'd0, ssum_r};
        div_b = {23'd0, scnt_r};
      end
      2'd2: begin
        div_a = {47'd0, tail_r} << pth_pkg::FracBits;
        div_b = {22'd0, {1'b0, scnt_r} + 18'd1};
      end
      2'd3: begin
        div_a = 64'd1 << pth_pkg::FracBits;
        div_b = {20'd0, nobs_r - 20'd1};
      end
      default: ;
    endcase
  end

  assign sq_go = (state_r == pth_pkg::ST_DIV) && div_done && dstep_r == 2'd3;
  pth_divider u_div (.clk(clk), .rst_n(rst_n), .go(div_go), .dividend(div_a),
                     .divisor(div_b), .done(div_done), .quotient(div_q));
  pth_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .go(sq_go), .radicand(var_val),
                   .done(sq_done), .root(sq_root));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pth_pkg::ST_CLEAR:
        if (clr_r == (BW+1)'(pth_pkg::MaxBins - 1)) state_nxt = pth_pkg::ST_IDLE;
      pth_pkg::ST_IDLE:
        if (do_start) state_nxt = pth_pkg::ST_CLEAR;
        else if (do_read) state_nxt = pth_pkg::ST_READ;
        else if (do_fin) state_nxt = pth_pkg::ST_DIV;
      pth_pkg::ST_READ: state_nxt = pth_pkg::ST_EMIT;
      pth_pkg::ST_DIV:  if (sq_go) state_nxt = pth_pkg::ST_SQRT;
      pth_pkg::ST_SQRT: if (sq_done) state_nxt = pth_pkg::ST_EMIT;
      pth_pkg::ST_EMIT: state_nxt = pth_pkg::ST_IDLE;
      default: state_nxt = pth_pkg::ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    busy = 1'b1;
    dstep_nxt = dstep_r;
    div_go = 1'b0;
    case (state_r)
      pth_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (do_fin) begin
          div_go = 1'b1;
          dstep_nxt = 2'd0;
        end
      end
      pth_pkg::ST_DIV:
        if (div_done && dstep_r != 2'd3) begin
          div_go = 1'b1;
          dstep_nxt = dstep_r + 2'd1;
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == pth_pkg::ST_DIV && div_done) begin
      case (dstep_r)
        2'd0: mean_r <= (scnt_r == '0) ? '0 : 18'(mean_full);
        2'd1: q_r <= div_q;
        2'd2: pp_r <= (div_q > 64'(1 << pth_pkg::FracBits)) ?
                      17'(1 << pth_pkg::FracBits) : div_q[16:0];
        2'd3: ev_r <= (nobs_r <= 20'd2) ? -17'sd65536 : 17'(-$signed({1'b0, div_q[16:0]}));
        default: ;
      endcase
    end
  end

  // run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pth_pkg::ST_CLEAR;
      dstep_r <= '0;
      clr_r <= '0;
      nbins_r <= nbins_calc;
      obsbin_r <= obs_bin_calc;
      minb_r <= obs_bin_calc;
      maxb_r <= obs_bin_calc;
      scnt_r <= '0;
      tail_r <= CW'(1);
      vsum_r <= '0;
      ssum_r <= '0;
    end else begin
      state_r <= state_nxt;
      dstep_r <= dstep_nxt;
      if (state_r == pth_pkg::ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (do_start) begin
        clr_r <= '0;
        nbins_r <= nbins_calc;
        obsbin_r <= obs_bin_calc;
        minb_r <= obs_bin_calc;
        maxb_r <= obs_bin_calc;
        scnt_r <= '0;
        tail_r <= CW'(1);
        vsum_r <= '0;
        ssum_r <= '0;
      end else if (do_add) begin
        scnt_r <= scnt_r + 1'b1;
        vsum_r <= vsum_r + 40'(in_sample_value);
        ssum_r <= ssum_r + 56'(36'($signed(in_sample_value) * $signed(in_sample_value)));
        if (((obs_r < 0) ? (in_sample_value <= obs_r) : (in_sample_value > obs_r))
            && tail_r != pth_pkg::CntMax) tail_r <= tail_r + 1'b1;
        if (sbin < minb_r) minb_r <= sbin;
        if (sbin > maxb_r) maxb_r <= sbin;
      end
    end
  end

  // result register
  logic is_read_r;
  always_ff @(posedge clk) begin
    if (state_r == pth_pkg::ST_READ) is_read_r <= 1'b1;
    else if (state_r == pth_pkg::ST_SQRT) is_read_r <= 1'b0;
  end

  // An add just before the read may have written the same bin at the read edge.
  logic [16:0] bc_r;
  always_ff @(posedge clk) begin
    if (state_r == pth_pkg::ST_READ) begin
      bc_r <= rd_oor_r ? '0 :
              (wb_v_r && wb_bin_r == rd_addr_r) ? wb_data_r : mem_rd;
    end
  end

  logic [16:0] sd_sat;
  assign sd_sat = (scnt_r == '0) ? '0 :
                  (sq_root > 32'd131071) ? 17'h1FFFF : sq_root[16:0];

  assign out_valid = (state_r == pth_pkg::ST_EMIT);
  assign out_result_kind = is_read_r;
  assign out_mean_value = is_read_r ? '0 : mean_r;
  assign out_std_dev = is_read_r ? '0 : sd_sat;
  assign out_pseudo_p = is_read_r ? '0 : pp_r;
  assign out_expected_value = is_read_r ? '0 : ev_r;
  assign out_extreme_count = is_read_r ? '0 : tail_r;
  assign out_sample_total = is_read_r ? '0 : scnt_r;
  assign out_lowest_bin = is_read_r ? '0 : minb_r;
  assign out_highest_bin = is_read_r ? '0 : maxb_r;
  assign out_observed_bin = is_read_r ? '0 : obsbin_r;
  assign out_bin_count = is_read_r ? bc_r : '0;

endmodule

FILE: hw/rtl/pth_divider.sv
// Restoring divider, one quotient bit per cycle, shared by all finish divisions.
// Standalone; does not use pth_pkg and has no other dependencies.
`timescale 1ns / 1ps
module pth_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] dividend,
  input  logic [39:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] q_r, q_nxt;
  logic [40:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [40:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[39:0], q_r[63]};
    if (go) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quotient = q_r;

endmodule

FILE: hw/rtl/pth_sqrt.sv
// Bit-pair integer square root, one result bit per cycle.
// Standalone; no package dependencies.
`timescale 1ns / 1ps
module pth_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v_r, v_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] r_r, r_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;
  logic [33:0] test;

  always_comb begin
    v_nxt = v_r;
    rem_nxt = rem_r;
    r_nxt = r_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[31:0], v_r[63:62]};
    test = {r_r, 2'b01};
    if (go) begin
      v_nxt = radicand;
      rem_nxt = '0;
      r_nxt = '0;
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      v_nxt = {v_r[61:0], 2'b00};
      if (trial >= test) begin
        rem_nxt = trial - test;
        r_nxt = {r_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial;
        r_nxt = {r_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    rem_r <= rem_nxt;
    r_r <= r_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = r_r;

endmodule

FILE: hw/rtl/pth_hist_mem.sv
// Histogram store: synchronous RAM with a registered read port and one write port.
// Depends on pth_pkg for widths.
`timescale 1ns / 1ps
module pth_hist_mem (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [pth_pkg::BinW-1:0]  rd_addr,
  output logic [pth_pkg::CntW-1:0]  rd_data,
  input  logic                      wr_en,
  input  logic [pth_pkg::BinW-1:0]  wr_addr,
  input  logic [pth_pkg::CntW-1:0]  wr_data
);

  logic [pth_pkg::CntW-1:0] mem [pth_pkg::MaxBins];
  logic [pth_pkg::CntW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/pth_checker.sv
// Port-level checker for permutation_test_histogram, bound to the top level.
// Depends on the top level's port list only.
`timescale 1ns / 1ps
module pth_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic        out_result_kind,
  input logic [16:0] out_bin_count,
  input logic [16:0] out_pseudo_p,
  input logic [16:0] out_extreme_count
);

  // A result never follows in the very next cycle after another.
  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back to back results");

  // No new request is taken while a result is on the outputs.
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while not busy");

  // A statistics record carries no bin count.
  a_stat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_kind |-> out_bin_count == 17'd0)
    else $error("bin count in statistics record");

  // p-value stays at or below one.
  a_pp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_kind |-> out_pseudo_p <= 17'd65536)
    else $error("p-value above one");

  // The extreme count includes the observed value itself.
  a_ext_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_kind |-> out_extreme_count != 17'd0)
    else $error("zero extreme count");

endmodule

bind permutation_test_histogram pth_checker u_pth_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_result_kind(out_result_kind), .out_bin_count(out_bin_count),
  .out_pseudo_p(out_pseudo_p), .out_extreme_count(out_extreme_count)
);

FILE: bench/testbench.sv
// Testbench for permutation_test_histogram: directed and random requests with
// a built-in histogram predictor and an in-order result checker. Depends on pth_pkg.
`timescale 1ns / 1ps
module testbench;
  import pth_pkg::*;

  localparam int CycleLimit = 2000000;

  typedef struct {
    logic        kind;
    logic [17:0] mean;
    logic [16:0] sdev;
    logic [16:0] pval;
    logic [16:0] expv;
    logic [16:0] tail;
    logic [16:0] total;
    logic [8:0]  lo_bin;
    logic [8:0]  hi_bin;
    logic [8:0]  obs_bin;
    logic [16:0] count;
  } hist_rec_t;

  logic clk, rst_n, start, busy;
  logic [1:0] in_action;
  logic signed [17:0] in_sample_value;
  logic [8:0] in_bin_index;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [19:0] cfg_data;
  logic out_valid, out_result_kind;
  logic signed [17:0] out_mean_value;
  logic [16:0] out_std_dev, out_pseudo_p;
  logic signed [16:0] out_expected_value;
  logic [16:0] out_extreme_count, out_sample_total;
  logic [8:0] out_lowest_bin, out_highest_bin, out_observed_bin;
  logic [16:0] out_bin_count;

  permutation_test_histogram uut (.*);

  // Predictor state.
  logic signed [17:0] obs_stat;
  int unsigned perm_cnt, obs_cnt;
  int unsigned hist_bins[MaxBins];
  int unsigned n_samples, n_tail, n_bins, obs_idx, lo_seen, hi_seen;
  longint sum_x;
  longint unsigned sum_sq;

  hist_rec_t expected_recs[$];
  int errors, checked, requests;
  int cycles;
  bit gaps_on;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int unsigned bin_for(longint x);
    longint t;
    longint unsigned idx;
    t = x + (longint'(1) << FracBits);
    if (t < 0) return 0;
    idx = (longint'(t) * n_bins) >> (FracBits + 1);
    if (idx >= n_bins) idx = n_bins - 1;
    return 32'(idx);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (longint'(1) << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic void restart_run();
    if (perm_cnt <= 10) n_bins = 10;
    else if (perm_cnt <= 100) n_bins = 20;
    else if (perm_cnt <= 1000) n_bins = (perm_cnt + 1) / 4;
    else n_bins = 300;
    if (n_bins > MaxBins) n_bins = MaxBins;
    obs_idx = bin_for(obs_stat);
    if (obs_idx < 1) obs_idx = 1;
    foreach (hist_bins[i]) hist_bins[i] = 0;
    hist_bins[obs_idx] = 1;
    n_samples = 0;
    n_tail = 1;
    sum_x = 0;
    sum_sq = 0;
    lo_seen = obs_idx;
    hi_seen = obs_idx;
  endfunction

  function automatic void apply_request(action_t act, logic signed [17:0] x,
                                        logic [8:0] bi);
    hist_rec_t rec;
    int unsigned b;
    bit hit;
    longint m;
    longint unsigned q, msq, sd, pp, one;
    rec = '{default: '0};
    one = longint'(1) << FracBits;
    case (act)
      ACT_START: restart_run();
      ACT_ADD: begin
        if (n_samples < CntMax) begin
          n_samples++;
          sum_x += longint'(x);
          sum_sq += longint'(x) * longint'(x);
          b = bin_for(x);
          if (hist_bins[b] < CntMax) hist_bins[b]++;
          hit = (obs_stat < 0) ? (x <= obs_stat) : (x > obs_stat);
          if (hit && n_tail < CntMax) n_tail++;
          if (b < lo_seen) lo_seen = b;
          if (b > hi_seen) hi_seen = b;
        end
      end
      ACT_READ: begin
        rec.kind = 1'b1;
        rec.count = (bi < n_bins) ? hist_bins[bi][16:0] : '0;
        expected_recs.push_back(rec);
      end
      default: begin
        m = 0;
        sd = 0;
        if (n_samples > 0) begin
          m = sum_x / longint'(n_samples);
          q = sum_sq / n_samples;
          msq = m * m;
          sd = root_floor(q >= msq ? q - msq : 0);
          if (sd > CntMax) sd = CntMax;
        end
        pp = (longint'(n_tail) << FracBits) / (n_samples + 1);
        if (pp > one) pp = one;
        rec.mean = m[17:0];
        rec.sdev = sd[16:0];
        rec.pval = pp[16:0];
        rec.expv = 17'((obs_cnt <= 2) ? -one : -(one / (obs_cnt - 1)));
        rec.tail = n_tail[16:0];
        rec.total = n_samples[16:0];
        rec.lo_bin = lo_seen[8:0];
        rec.hi_bin = hi_seen[8:0];
        rec.obs_bin = obs_idx[8:0];
        expected_recs.push_back(rec);
      end
    endcase
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Results are sampled at the edge that ends their cycle.
  always @(posedge clk) begin
    hist_rec_t e;
    if (rst_n && out_valid) begin
      if (expected_recs.size() == 0) begin
        $error("result_kind: expected no result, got %0d", out_result_kind);
        errors++;
      end else begin
        e = expected_recs.pop_front();
        checked++;
        check_field("result_kind", e.kind, out_result_kind);
        check_field("mean_value", e.mean, $unsigned(out_mean_value));
        check_field("std_dev", e.sdev, out_std_dev);
        check_field("pseudo_p", e.pval, out_pseudo_p);
        check_field("expected_value", e.expv, $unsigned(out_expected_value));
        check_field("extreme_count", e.tail, out_extreme_count);
        check_field("sample_total", e.total, out_sample_total);
        check_field("lowest_bin", e.lo_bin, out_lowest_bin);
        check_field("highest_bin", e.hi_bin, out_highest_bin);
        check_field("observed_bin", e.obs_bin, out_observed_bin);
        check_field("bin_count", e.count, out_bin_count);
      end
    end
  end

  // Leaves start high; pause(), called at random while gaps_on is set, and drain() lower it.
  task automatic send(action_t act, logic signed [17:0] x = '0, logic [8:0] bi = '0);
    bit was_busy;
    start <= 1'b1;
    in_action <= act;
    in_sample_value <= x;
    in_bin_index <= bi;
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
    apply_request(act, x, bi);
    requests++;
    if (gaps_on && $urandom_range(0, 5) == 0) pause($urandom_range(1, 16));
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    in_action <= action_t'($urandom_range(0, 3));
    in_sample_value <= 18'($urandom);
    in_bin_index <= 9'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // Waits until every request has answered and the pipeline has drained.
  task automatic drain();
    bit was_busy;
    start <= 1'b0;
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy || expected_recs.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [19:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_OBS:  obs_stat = val[17:0];
      CFG_PERM: perm_cnt = 32'(val[16:0]);
      default:  obs_cnt = 32'(val);
    endcase
  endtask

  task automatic set_config(logic signed [17:0] o, int unsigned p, int unsigned nobs);
    drain();
    write_reg(CFG_OBS, 20'(o));
    write_reg(CFG_PERM, 20'(p));
    write_reg(CFG_NOBS, 20'(nobs));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [17:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 18'sh20000;
      1: return 18'sh1FFFF;
      2: return 18'sh10000;
      3: return -18'sh10000;
      4: return 18'sd0;
      default: return 18'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    logic signed [17:0] vals[9] = '{18'sh20000, 18'sh1FFFF, -18'sh10000, 18'sh0FFFF,
                                    18'sh10000, 18'sd0, -18'sd1, -18'sd13107,
                                    -18'sd13106};
    set_config(-18'sd13107, 999, 100);
    send(ACT_START);
    foreach (vals[i]) send(ACT_ADD, vals[i]);
    send(ACT_READ, 0, 9'd0);
    send(ACT_READ, 0, 9'd248);
    send(ACT_READ, 0, 9'd249);
    send(ACT_READ, 0, 9'd511);
    send(ACT_FINISH);
    send(ACT_START);
    send(ACT_FINISH);
  endtask

  task automatic test_bin_counts();
    int unsigned perms[8] = '{1, 10, 11, 100, 101, 1000, 1001, 99999};
    foreach (perms[i]) begin
      set_config(18'sd0, perms[i], 100);
      send(ACT_START);
      send(ACT_ADD, 18'sh1FFFF);
      send(ACT_READ, 0, 9'(n_bins - 1));
      send(ACT_FINISH);
    end
  endtask

  task automatic test_registers();
    set_config(18'sh1FFFF, 5, 2);
    send(ACT_START);
    send(ACT_ADD, 18'sh1FFFF);
    send(ACT_FINISH);
    set_config(-18'sh20000, 50, 3);
    send(ACT_START);
    send(ACT_ADD, -18'sh20000);
    send(ACT_FINISH);
    set_config(18'sd0, 500, 1048575);
    send(ACT_START);
    send(ACT_ADD, 18'sd1);
    send(ACT_FINISH);
  endtask

  task automatic test_random(int total);
    int sent, n_adds, choice;
    int unsigned p;
    sent = 0;
    while (sent < total) begin
      gaps_on = (sent < total * 4 / 5);
      if ($urandom_range(0, 2) == 0) begin
        choice = $urandom_range(0, 4);
        p = (choice == 0) ? $urandom_range(1, 10) : (choice == 1) ? $urandom_range(11, 100) :
            (choice == 2) ? $urandom_range(101, 1000) : $urandom_range(1001, 99999);
        set_config($urandom % 2 ? pick_sample() : 18'($urandom),
                   $urandom_range(0, 3) == 0 ? 17'h1FFFF & p : p,
                   $urandom_range(0, 4) == 0 ? 2 : $urandom_range(2, 1048575));
      end
      send(ACT_START);
      n_adds = $urandom_range(3, 40);
      for (int i = 0; i < n_adds; i++) begin
        choice = $urandom_range(0, 19);
        if (choice < 14) send(ACT_ADD, pick_sample());
        else if (choice < 18)
          send(ACT_READ, 0, $urandom_range(0, 3) == 0 ? 9'($urandom) : 9'($urandom_range(0, n_bins - 1)));
        else if (choice == 18) send(ACT_FINISH);
        else send(action_t'($urandom_range(1, 3)), 18'($urandom), 9'($urandom));
      end
      send(ACT_FINISH);
      sent += n_adds + 2;
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_action <= ACT_START;
    in_sample_value <= '0;
    in_bin_index <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_OBS;
    cfg_data <= '0;
    gaps_on = 1'b1;
    obs_stat = 0;
    perm_cnt = 999;
    obs_cnt = 100;
    restart_run();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_bin_counts();
    test_registers();
    test_random(490);
    drain();
    repeat (300) @(posedge clk);
    $display("Sent %0d requests over all actions, bin sizes and edge samples;", requests);
    $display("%0d result records compared, %0d field errors.", checked, errors);
    if (errors == 0 && expected_recs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
